### rtl/core/ppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared widths and opcodes of the parity phase rotation merger.
// ----------------------------------------------------------------------------
package ppr_pkg;

  // Fixed field widths of the stream beats
  localparam int unsigned OP_W    = 3;
  localparam int unsigned QIDX_W  = 4;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned SLOT_W  = 6;

  // Gate opcodes carried on the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_CNOT  = 3'd1,
    OP_NOT   = 3'd2,
    OP_RZ    = 3'd3,
    OP_SWAP  = 3'd4
  } op_e;

  // One finished rz result, waiting for the output register
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               merged;
    logic [ANGLE_W-1:0] total_angle;
    logic               table_full;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/parity_phase_rotation_merger_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parity_phase_rotation_merger_unit
// Tracks qubit parity phases through cnot/not/swap gates and folds rz
// rotations of equal phase into entries of a rotation table.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         qubit_a[3:0] qubit_b[7:4] angle[39:8]       operation[2:0]
//  m_axis    out        slot[5:0] total_angle[37:6]                 merged[0] table_full[1]
//
// One beat is taken at a time. A swap writes its two qubits in turn,
// in exec and then swap2 (one write port on the phase memory). An rz runs
// a linear table search that stops at the first match or after the last
// used entry, one entry read per cycle from the table memory. A
// finished rz result waits in a holding register only while the output
// register is still full. Reset clears the qubit valid bits and the fill
// count; table memory contents need no clearing.
// ----------------------------------------------------------------------------
module parity_phase_rotation_merger_unit #(
  parameter int unsigned QUBITS        = 16,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // qubit_a, qubit_b, angle
  input  wire logic [2:0]  s_axis_tuser,  // operation
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,  // slot, total_angle, zero pad
  output      logic [1:0]  m_axis_tuser   // merged, table_full
);

  localparam int unsigned PW = QUBITS + 1;
  localparam int unsigned QW = (QUBITS > 1) ? $clog2(QUBITS) : 1;
  localparam int unsigned TW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = TW + 1;
  localparam int unsigned AGW = ppr_pkg::ANGLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP2,
    ST_SEARCH,
    ST_APPEND,
    ST_DONE
  } state_e;

  state_e                     state_q;
  ppr_pkg::op_e               op_q;
  logic [ppr_pkg::QIDX_W-1:0] qa_q, qb_q;
  logic [AGW-1:0]             ang_q;
  logic [TW-1:0]              cmp_k_q;
  logic [CW-1:0]              used_q;
  ppr_pkg::result_t           res_q;
  ppr_pkg::result_t           out_q;
  logic                       out_valid_q;

  // Phase memory ports
  logic          ph_clear, ph_rd_en, ph_wr_en;
  logic [QW-1:0] ph_wr_addr;
  logic [PW-1:0] ph_wr_data, pa, pb;

  // Rotation table ports
  logic           rt_rd_en, rt_wr_en;
  logic [TW-1:0]  rt_rd_addr, rt_wr_addr;
  logic [PW-1:0]  rt_rd_phase, rt_wr_phase;
  logic [AGW-1:0] rt_rd_angle, rt_wr_angle;

  logic           s_accept, ok_a, ok_b, match, last_k, has_room;
  logic [AGW-1:0] sum_angle;
  ppr_pkg::op_e   s_op;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign s_op          = ppr_pkg::op_e'(s_axis_tuser);

  assign ok_a      = 32'(qa_q) < 32'(QUBITS);
  assign ok_b      = 32'(qb_q) < 32'(QUBITS);
  assign match     = (rt_rd_phase == pa);
  assign last_k    = (CW'(cmp_k_q) + CW'(1)) == used_q;
  assign has_room  = 32'(used_q) < 32'(TABLE_ENTRIES);
  assign sum_angle = rt_rd_angle + ang_q;

  ppr_phase_store #(
    .QUBITS (QUBITS),
    .AW     (QW)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (ph_clear),
    .rd_en_i     (ph_rd_en),
    .rd_addr_a_i (QW'(s_axis_tdata[3:0])),
    .rd_addr_b_i (QW'(s_axis_tdata[7:4])),
    .rd_data_a_o (pa),
    .rd_data_b_o (pb),
    .wr_en_i     (ph_wr_en),
    .wr_addr_i   (ph_wr_addr),
    .wr_data_i   (ph_wr_data)
  );

  ppr_rot_store #(
    .ENTRIES (TABLE_ENTRIES),
    .PW      (PW),
    .AW      (TW)
  ) u_rot (
    .clk_i      (clk_i),
    .rd_en_i    (rt_rd_en),
    .rd_addr_i  (rt_rd_addr),
    .rd_phase_o (rt_rd_phase),
    .rd_angle_o (rt_rd_angle),
    .wr_en_i    (rt_wr_en),
    .wr_addr_i  (rt_wr_addr),
    .wr_phase_i (rt_wr_phase),
    .wr_angle_i (rt_wr_angle)
  );

  // Phase memory control: read both qubits on accept, write back in exec and swap2
  always_comb begin
    ph_clear   = s_accept && (s_op == ppr_pkg::OP_START);
    ph_rd_en   = s_accept;
    ph_wr_en   = 1'b0;
    ph_wr_addr = QW'(qa_q);
    ph_wr_data = pb;
    if (state_q == ST_EXEC) begin
      case (op_q)
        ppr_pkg::OP_CNOT: begin
          ph_wr_en   = ok_a & ok_b;
          ph_wr_addr = QW'(qb_q);
          ph_wr_data = pb ^ pa;
        end
        ppr_pkg::OP_NOT: begin
          ph_wr_en   = ok_a;
          ph_wr_data = pa ^ {1'b1, {QUBITS{1'b0}}};
        end
        ppr_pkg::OP_SWAP: begin
          ph_wr_en   = ok_a & ok_b;
          ph_wr_data = pb;
        end
        default: ph_wr_en = 1'b0;
      endcase
    end else if (state_q == ST_SWAP2) begin
      ph_wr_en   = 1'b1;
      ph_wr_addr = QW'(qb_q);
      ph_wr_data = pa;
    end
  end

  // Table control: streaming read one entry ahead, update or append
  always_comb begin
    rt_rd_en    = 1'b0;
    rt_rd_addr  = '0;
    rt_wr_en    = 1'b0;
    rt_wr_addr  = cmp_k_q;
    rt_wr_phase = pa;
    rt_wr_angle = sum_angle;
    case (state_q)
      ST_EXEC: begin
        rt_rd_en = (op_q == ppr_pkg::OP_RZ) && ok_a && (used_q != '0);
      end
      ST_SEARCH: begin
        rt_rd_en   = !match && !last_k;
        rt_rd_addr = cmp_k_q + TW'(1);
        rt_wr_en   = match;
      end
      ST_APPEND: begin
        rt_wr_en    = has_room;
        rt_wr_addr  = used_q[TW-1:0];
        rt_wr_angle = ang_q;
      end
      default: rt_rd_en = 1'b0;
    endcase
  end

  // Sequencer, fill count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= ppr_pkg::OP_START;
      qa_q        <= '0;
      qb_q        <= '0;
      ang_q       <= '0;
      cmp_k_q     <= '0;
      used_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output drains; a result loaded in done keeps it valid
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            op_q  <= s_op;
            qa_q  <= s_axis_tdata[3:0];
            qb_q  <= s_axis_tdata[7:4];
            ang_q <= s_axis_tdata[39:8];
            if (s_op == ppr_pkg::OP_START) begin
              used_q <= '0;
            end else begin
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          case (op_q)
            ppr_pkg::OP_SWAP: begin
              state_q <= (ok_a && ok_b) ? ST_SWAP2 : ST_IDLE;
            end
            ppr_pkg::OP_RZ: begin
              if (ok_a) begin
                cmp_k_q <= '0;
                state_q <= (used_q == '0) ? ST_APPEND : ST_SEARCH;
              end else begin
                state_q <= ST_IDLE;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_SWAP2: begin
          state_q <= ST_IDLE;
        end
        ST_SEARCH: begin
          if (match) begin
            res_q.slot        <= ppr_pkg::SLOT_W'(cmp_k_q);
            res_q.merged      <= 1'b1;
            res_q.total_angle <= sum_angle;
            res_q.table_full  <= 1'b0;
            state_q           <= ST_DONE;
          end else if (last_k) begin
            state_q <= ST_APPEND;
          end else begin
            cmp_k_q <= cmp_k_q + TW'(1);
          end
        end
        ST_APPEND: begin
          res_q.merged      <= 1'b0;
          res_q.total_angle <= ang_q;
          if (has_room) begin
            res_q.slot       <= ppr_pkg::SLOT_W'(used_q);
            res_q.table_full <= 1'b0;
            used_q           <= used_q + CW'(1);
          end else begin
            res_q.slot       <= '0;
            res_q.table_full <= 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.total_angle, out_q.slot};
  assign m_axis_tuser  = {out_q.table_full, out_q.merged};

endmodule
`default_nettype wire

### rtl/core/ppr_phase_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_phase_store
// Per-qubit parity phase memory: two registered read ports, one write port.
// A valid bit per qubit makes an unwritten entry read as its own variable.
// ----------------------------------------------------------------------------
module ppr_phase_store #(
  parameter int unsigned QUBITS = 16,
  parameter int unsigned AW     = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_a_i,
  input  wire logic [AW-1:0]     rd_addr_b_i,
  output      logic [QUBITS:0]   rd_data_a_o,
  output      logic [QUBITS:0]   rd_data_b_o,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [QUBITS:0]   wr_data_i
);

  logic [QUBITS:0] mem [QUBITS];
  logic [QUBITS-1:0] valid_q;

  logic [QUBITS:0] data_a_q, data_b_q;
  logic [AW-1:0]   addr_a_q, addr_b_q;
  logic            vld_a_q, vld_b_q;

  // Storage and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_a_q <= mem[rd_addr_a_i];
      data_b_q <= mem[rd_addr_b_i];
      addr_a_q <= rd_addr_a_i;
      addr_b_q <= rd_addr_b_i;
    end
  end

  // Valid bits: start clears all, a write marks its entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= valid_q[rd_addr_a_i] & ~clear_i;
        vld_b_q <= valid_q[rd_addr_b_i] & ~clear_i;
      end
    end
  end

  // Unwritten qubit holds only its own variable
  assign rd_data_a_o = vld_a_q ? data_a_q : ((QUBITS+1)'(1) << addr_a_q);
  assign rd_data_b_o = vld_b_q ? data_b_q : ((QUBITS+1)'(1) << addr_b_q);

endmodule
`default_nettype wire

### rtl/core/ppr_rot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppr_rot_store
// Rotation table memory: phase and accumulated angle per entry,
// one write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ppr_rot_store #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned PW      = 17,
  parameter int unsigned AW      = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output      logic [PW-1:0]               rd_phase_o,
  output      logic [ppr_pkg::ANGLE_W-1:0] rd_angle_o,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [PW-1:0]               wr_phase_i,
  input  wire logic [ppr_pkg::ANGLE_W-1:0] wr_angle_i
);

  localparam int unsigned DW = PW + ppr_pkg::ANGLE_W;

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rd_q;

  // Single-port style write, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_phase_i, wr_angle_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_phase_o = rd_q[DW-1:ppr_pkg::ANGLE_W];
  assign rd_angle_o = rd_q[ppr_pkg::ANGLE_W-1:0];

endmodule
`default_nettype wire

### tb/parity_phase_rotation_merger_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_phase_rotation_merger_unit_tb
// Drives gate beats into the merger and checks every rz result against a
// local phase tracker and rotation table. Directed gate edge cases come
// first. A table overflow run follows, and then random subcircuits. The
// sender idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module parity_phase_rotation_merger_unit_tb;

  localparam int unsigned QUBITS        = 16;
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned RANDOM_GATES  = 1300;

  // Opcodes the block does not know; it drops them
  localparam logic [ppr_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [ppr_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [ppr_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // qubit_a[3:0], qubit_b[7:4], angle[39:8]
  logic [2:0]  s_axis_tuser  = '0;  // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // slot[5:0], total_angle[37:6], zero pad
  logic [1:0]  m_axis_tuser;        // merged[0], table_full[1]

  parity_phase_rotation_merger_unit #(
    .QUBITS        (QUBITS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Phase tracker and rotation table
  logic [QUBITS:0]   qubit_parity [QUBITS];
  logic [QUBITS:0]   table_parity [TABLE_ENTRIES];
  logic [31:0]       table_angle  [TABLE_ENTRIES];
  int unsigned       table_fill;
  int unsigned       overflow_hits;
  ppr_pkg::result_t  pending_rotations [$];

  int unsigned       mismatch_count = 0;
  int unsigned       gates_sent;
  int unsigned       burst_left;

  task automatic restart_parities();
    for (int q = 0; q < QUBITS; q++) begin
      qubit_parity[q] = '0;
      qubit_parity[q][q] = 1'b1;
    end
    table_fill = 0;
  endtask

  // Apply one accepted gate; rz queues the result it must give
  task automatic fold_gate(input logic [ppr_pkg::OP_W-1:0] op, input logic [3:0] qa,
                           input logic [3:0] qb, input logic [31:0] ang);
    logic [QUBITS:0]  held;
    ppr_pkg::result_t res;
    bit               hit;
    case (op)
      ppr_pkg::OP_START: restart_parities();
      ppr_pkg::OP_CNOT:  qubit_parity[qb] = qubit_parity[qb] ^ qubit_parity[qa];
      ppr_pkg::OP_NOT:   qubit_parity[qa][QUBITS] = ~qubit_parity[qa][QUBITS];
      ppr_pkg::OP_SWAP: begin
        held             = qubit_parity[qa];
        qubit_parity[qa] = qubit_parity[qb];
        qubit_parity[qb] = held;
      end
      ppr_pkg::OP_RZ: begin
        hit = 1'b0;
        res = '0;
        for (int k = 0; k < table_fill; k++) begin
          if (!hit && table_parity[k] == qubit_parity[qa]) begin
            hit             = 1'b1;
            table_angle[k]  = table_angle[k] + ang;
            res.slot        = k[ppr_pkg::SLOT_W-1:0];
            res.merged      = 1'b1;
            res.total_angle = table_angle[k];
          end
        end
        if (!hit) begin
          res.total_angle = ang;
          if (table_fill < TABLE_ENTRIES) begin
            table_parity[table_fill] = qubit_parity[qa];
            table_angle[table_fill]  = ang;
            res.slot                 = table_fill[ppr_pkg::SLOT_W-1:0];
            table_fill++;
          end else begin
            res.table_full = 1'b1;
            overflow_hits++;
          end
        end
        pending_rotations = {pending_rotations, res};
      end
      default: ;
    endcase
  endtask

  // One beat through the slave port, with bursty idling in front
  task automatic send_gate(input logic [ppr_pkg::OP_W-1:0] op, input logic [3:0] qa,
                           input logic [3:0] qb, input logic [31:0] ang);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(40, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, qb, qa};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_gate(op, qa, qb, ang);
    gates_sent++;
  endtask

  // Hold the sender until every rz result is back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_rotations.size() != 0);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_qubit();
    return 4'($urandom_range(QUBITS - 1));
  endfunction

  // Receiver: check each result beat, then choose next ready
  int unsigned      rx_cycle = 0;
  int unsigned      rx_mode  = 0;
  ppr_pkg::result_t head;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rotations.size() == 0) begin
        $display("%0t: result beat with none pending: tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        head = pending_rotations.pop_front();
        if (m_axis_tdata[5:0] !== head.slot) begin
          $display("%0t: slot expected %0d actual %0d",
                   $time, head.slot, m_axis_tdata[5:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[37:6] !== head.total_angle) begin
          $display("%0t: total_angle expected %h actual %h",
                   $time, head.total_angle, m_axis_tdata[37:6]);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== head.merged) begin
          $display("%0t: merged expected %b actual %b",
                   $time, head.merged, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[1] !== head.table_full) begin
          $display("%0t: table_full expected %b actual %b",
                   $time, head.table_full, m_axis_tuser[1]);
          mismatch_count++;
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'hff) rx_mode <= $urandom_range(3);
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(3) != 0);
      2:       m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= rx_cycle[4];
    endcase
  end

  // Extreme angles, wraparound and merging on untouched qubits
  task automatic test_rotation_merge();
    send_gate(ppr_pkg::OP_RZ, 4'd0,  4'd15, 32'h0000_0000);
    send_gate(ppr_pkg::OP_RZ, 4'd15, 4'd0,  32'h7fff_ffff);
    send_gate(ppr_pkg::OP_RZ, 4'd15, 4'd15, 32'h0000_0001);
    send_gate(ppr_pkg::OP_RZ, 4'd0,  4'd0,  32'hffff_ffff);
    send_gate(ppr_pkg::OP_RZ, 4'd0,  4'd7,  32'h8000_0000);
  endtask

  // Self cnot, not twice, swap with itself, unknown ops, restart
  task automatic test_gate_corners();
    send_gate(ppr_pkg::OP_CNOT, 4'd3, 4'd3, 32'h0);
    send_gate(ppr_pkg::OP_RZ,   4'd3, 4'd0, 32'h1234_5678);
    send_gate(ppr_pkg::OP_NOT,  4'd5, 4'd9, 32'h0);
    send_gate(ppr_pkg::OP_RZ,   4'd5, 4'd0, 32'h0000_0100);
    send_gate(ppr_pkg::OP_NOT,  4'd5, 4'd0, 32'h0);
    send_gate(ppr_pkg::OP_RZ,   4'd5, 4'd0, 32'h0000_0200);
    send_gate(ppr_pkg::OP_SWAP, 4'd7, 4'd7, 32'h0);
    send_gate(ppr_pkg::OP_SWAP, 4'd2, 4'd9, 32'h0);
    send_gate(ppr_pkg::OP_RZ,   4'd2, 4'd0, 32'h0000_0300);
    send_gate(ppr_pkg::OP_RZ,   4'd9, 4'd0, 32'h0000_0400);
    send_gate(ppr_pkg::OP_CNOT, 4'd0, 4'd15, 32'h0);
    send_gate(ppr_pkg::OP_RZ,   4'd15, 4'd0, 32'hdead_beef);
    send_gate(OP_UNUSED_LO,  4'd1, 4'd2, 32'hffff_ffff);
    send_gate(OP_UNUSED_MID, 4'd15, 4'd15, 32'h0);
    send_gate(OP_UNUSED_HI,  4'd4, 4'd8, 32'h5555_aaaa);
    send_gate(ppr_pkg::OP_START, 4'd0, 4'd0, 32'h0);
    send_gate(ppr_pkg::OP_RZ,    4'd0, 4'd0, 32'h0000_0001);
  endtask

  // Scramble phases until the table fills and rejects three rotations
  task automatic test_table_overflow();
    int unsigned target;
    int unsigned guard;
    int unsigned r;
    target = overflow_hits + 3;
    guard  = 0;
    send_gate(ppr_pkg::OP_START, pick_qubit(), pick_qubit(), $urandom());
    while (overflow_hits < target && guard < 3000) begin
      r = $urandom_range(99);
      if (r < 50)
        send_gate(ppr_pkg::OP_RZ,   pick_qubit(), pick_qubit(), pick_angle());
      else if (r < 85)
        send_gate(ppr_pkg::OP_CNOT, pick_qubit(), pick_qubit(), $urandom());
      else
        send_gate(ppr_pkg::OP_NOT,  pick_qubit(), pick_qubit(), $urandom());
      guard++;
    end
    wait_results_drained();
  endtask

  // Mostly well-formed subcircuits with random gates, plus noise
  task automatic test_random_subcircuits();
    int unsigned first;
    int unsigned span;
    int unsigned r;
    first = gates_sent;
    while (gates_sent - first < RANDOM_GATES) begin
      if ($urandom_range(9) != 0)
        send_gate(ppr_pkg::OP_START, pick_qubit(), pick_qubit(), $urandom());
      span = ($urandom_range(3) != 0) ? $urandom_range(40, 4) : $urandom_range(250, 60);
      repeat (span) begin
        r = $urandom_range(99);
        if (r < 40)
          send_gate(ppr_pkg::OP_RZ,   pick_qubit(), pick_qubit(), pick_angle());
        else if (r < 60)
          send_gate(ppr_pkg::OP_CNOT, pick_qubit(), pick_qubit(), $urandom());
        else if (r < 72)
          send_gate(ppr_pkg::OP_NOT,  pick_qubit(), pick_qubit(), $urandom());
        else if (r < 87)
          send_gate(ppr_pkg::OP_SWAP, pick_qubit(), pick_qubit(), $urandom());
        else if (r < 95)
          send_gate(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                    pick_qubit(), pick_qubit(), $urandom());
        else
          send_gate(ppr_pkg::OP_START, pick_qubit(), pick_qubit(), $urandom());
      end
    end
  endtask

  initial begin
    gates_sent     = 0;
    burst_left     = 0;
    overflow_hits  = 0;
    restart_parities();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rotation_merge();
    test_gate_corners();
    test_table_overflow();
    test_random_subcircuits();

    // Drain, then let a final search finish
    wait_results_drained();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rotations.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
